// ----- design/krt_pkg.sv -----
// Shared types and constants for the keyed record table.
package krt_pkg;

  // Request operation codes.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_SELECT = 2'd2;
  localparam logic [1:0] MODE_UPDATE = 2'd3;

  // Field widths fixed by the request and response formats.
  localparam int KEY_W   = 32;
  localparam int PAY_W   = 64;
  localparam int COUNT_W = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // latch a new request and restart the scan
    logic scan;     // step the linear search
    logic hit;      // record the matching entry
    logic wr;       // insert at the end or update the matching entry
    logic del_rd;   // read the last filled entry
    logic del_wr;   // move the last entry into the freed slot
    logic load;     // load the response register
  } krt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       hit;       // the entry just read holds the request key
    logic       scan_end;  // every filled entry was compared without a match
    logic       full;      // fill count equals the depth
    logic       out_free;  // the response register can take a new result
    logic [1:0] mode;      // operation of the request in progress
  } krt_stat_t;

endpackage

// ----- design/krt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module krt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/krt_ctrl.sv -----
// Controller state machine that sequences search, write-back and response.
module krt_ctrl
  import krt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  krt_stat_t stat,
  output krt_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_DWR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // A new request is taken only in the idle state.
  assign in_stall = rst || (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.hit = 1'b1;
          case (stat.mode)
            MODE_DELETE: state_next = S_DRD;
            MODE_UPDATE: state_next = S_WR;
            default:     state_next = S_DONE;
          endcase
        end else if (stat.scan_end) begin
          if ((stat.mode == MODE_INSERT) && !stat.full) begin
            state_next = S_WR;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_WR: begin
        cmd.wr     = 1'b1;
        state_next = S_DONE;
      end
      S_DRD: begin
        cmd.del_rd = 1'b1;
        state_next = S_DWR;
      end
      S_DWR: begin
        cmd.del_wr = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/krt_dp.sv -----
// Datapath: request registers, scan counter, record memories and response register.
module krt_dp
  import krt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  krt_cmd_t                 cmd,
  output krt_stat_t                stat,
  input  logic [1:0]               mode,
  input  logic signed [KEY_W-1:0]  key,
  input  logic [PAY_W-1:0]         payload,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     ok,
  output logic [PAY_W-1:0]         payload_out,
  output logic [COUNT_W-1:0]       entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Latched request.
  logic [1:0]       req_mode;
  logic [KEY_W-1:0] req_key;
  logic [PAY_W-1:0] req_payload;

  // Scan and table state.
  logic [CW-1:0]    fill;
  logic [CW-1:0]    idx;
  logic             pend;
  logic [AW-1:0]    pidx;
  logic [AW-1:0]    hit_idx;
  logic             res_ok;
  logic [PAY_W-1:0] res_pay;

  // Memory ports.
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [CW-1:0]    last;
  logic [KEY_W-1:0] key_wdata;
  logic [KEY_W-1:0] key_rdata;
  logic [PAY_W-1:0] pay_wdata;
  logic [PAY_W-1:0] pay_rdata;

  assign last = fill - CW'(1);

  // Read the scan position, or the last entry when a delete compacts the table.
  assign raddr = cmd.del_rd ? last[AW-1:0] : idx[AW-1:0];

  // Writes: append on insert, overwrite on update, move the last entry on delete.
  assign we        = cmd.wr || cmd.del_wr;
  assign waddr     = (cmd.wr && (req_mode == MODE_INSERT)) ? fill[AW-1:0] : hit_idx;
  assign key_wdata = cmd.del_wr ? key_rdata : req_key;
  assign pay_wdata = cmd.del_wr ? pay_rdata : req_payload;

  krt_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  krt_ram #(.WIDTH(PAY_W), .DEPTH(DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (pay_wdata),
    .raddr (raddr),
    .rdata (pay_rdata)
  );

  // Status toward the controller.
  assign stat.hit      = pend && (key_rdata == req_key);
  assign stat.scan_end = !pend && (idx >= fill);
  assign stat.full     = (fill == CW'(DEPTH));
  assign stat.out_free = !out_valid || !out_stall;
  assign stat.mode     = req_mode;

  // Request capture, linear search and result building.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode    <= mode;
      req_key     <= key;
      req_payload <= payload;
      res_ok      <= 1'b0;
      res_pay     <= '0;
    end
    if (cmd.scan && (idx < fill)) begin
      pidx <= idx[AW-1:0];
    end
    if (cmd.hit) begin
      hit_idx <= pidx;
      if (req_mode == MODE_SELECT) begin
        res_ok  <= 1'b1;
        res_pay <= pay_rdata;
      end
    end
    if (cmd.wr || cmd.del_wr) begin
      res_ok <= 1'b1;
    end
  end

  // Scan counter, pending-read flag and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      idx  <= '0;
      pend <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (cmd.scan) begin
        if (idx < fill) begin
          pend <= 1'b1;
          idx  <= idx + CW'(1);
        end else begin
          pend <= 1'b0;
        end
      end
      if (cmd.wr && (req_mode == MODE_INSERT)) begin
        fill <= fill + CW'(1);
      end else if (cmd.del_wr) begin
        fill <= last;
      end
    end
  end

  // Response register; a finished result waits here until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok          <= res_ok;
      payload_out <= res_pay;
      entry_count <= COUNT_W'(fill);
    end
  end

endmodule

// ----- design/keyed_record_table_core.sv -----
// Top level of the keyed record table: linear-search key and payload store.
//
//   channel   direction  handshake            fields
//   request   in         in_valid / in_stall  mode, key, payload
//   response  out        out_valid/ out_stall ok, payload_out, entry_count
//
// A request runs a linear search that reads one stored key per cycle from the
// key memory, then a write-back (a delete reads the last entry first, then
// moves it into the freed slot) and a load of the response register. One
// request is in progress at a time; a new one is taken while the previous
// response still waits under out_stall.
// Reset (rst, synchronous) empties the table; no clearing pass is needed.
module keyed_record_table_core
  import krt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               mode,
  input  logic signed [KEY_W-1:0]  key,
  input  logic [PAY_W-1:0]         payload,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     ok,
  output logic [PAY_W-1:0]         payload_out,
  output logic [COUNT_W-1:0]       entry_count
);

  krt_cmd_t  cmd;
  krt_stat_t stat;

  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  krt_dp #(.DEPTH(DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .key         (key),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .payload_out (payload_out),
    .entry_count (entry_count)
  );

  // After a transaction is taken the block is busy with the search.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while a search was starting");

  // A failed request never returns a payload.
  a_fail_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (payload_out == '0))
    else $error("failed request carries a nonzero payload");

  // The reported count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(entry_count) <= 32'(DEPTH)))
    else $error("entry count above table depth");

endmodule

// ----- test/tb_keyed_record_table_core.sv -----
// Self-checking testbench for the keyed record table core with a scoreboard and random traffic.
module tb_keyed_record_table_core
  import krt_pkg::*;
();

  localparam int DEPTH      = 64;
  localparam int POOL_SIZE  = 96;
  localparam int HOLD_LEN   = 400;
  localparam int MAX_CYCLES = 1000000;

  // One response as the block should present it.
  typedef struct packed {
    logic               ok;
    logic [PAY_W-1:0]   payload_out;
    logic [COUNT_W-1:0] entry_count;
  } response_t;

  // Scoreboard: keeps its own copy of the table and checks responses in order.
  class record_scoreboard;
    logic [KEY_W-1:0] key_mem[DEPTH];
    logic [PAY_W-1:0] pay_mem[DEPTH];
    int               fill;
    response_t        pending_responses[$];
    int               mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_responses.size();
    endfunction

    // Applies one accepted request to the table copy and queues its response.
    function void note_request(logic [1:0] m, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
      int        hit;
      response_t resp;
      hit  = -1;
      resp = '0;
      for (int i = 0; i < fill; i++) begin
        if (hit < 0 && key_mem[i] == k) hit = i;
      end
      case (m)
        MODE_INSERT: begin
          if (hit < 0 && fill < DEPTH) begin
            key_mem[fill] = k;
            pay_mem[fill] = p;
            fill++;
            resp.ok = 1'b1;
          end
        end
        MODE_DELETE: begin
          if (hit >= 0) begin
            key_mem[hit] = key_mem[fill-1];
            pay_mem[hit] = pay_mem[fill-1];
            fill--;
            resp.ok = 1'b1;
          end
        end
        MODE_SELECT: begin
          if (hit >= 0) begin
            resp.payload_out = pay_mem[hit];
            resp.ok          = 1'b1;
          end
        end
        default: begin
          if (hit >= 0) begin
            pay_mem[hit] = p;
            resp.ok      = 1'b1;
          end
        end
      endcase
      resp.entry_count = fill[COUNT_W-1:0];
      pending_responses.push_back(resp);
    endfunction

    // Compares one accepted response with the oldest expectation.
    function void check_response(logic o, logic [PAY_W-1:0] po, logic [COUNT_W-1:0] cnt);
      response_t want;
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected response: ok=%0b payload_out=%h entry_count=%0d", o, po, cnt);
        return;
      end
      want = pending_responses.pop_front();
      if (want.ok !== o || want.payload_out !== po || want.entry_count !== cnt) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Mismatch: expected ok=%0b payload_out=%h entry_count=%0d, ",
                    "got ok=%0b payload_out=%h entry_count=%0d"},
                   want.ok, want.payload_out, want.entry_count, o, po, cnt);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = MODE_INSERT;
  logic [KEY_W-1:0]   key = '0;
  logic [PAY_W-1:0]   payload = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               ok;
  logic [PAY_W-1:0]   payload_out;
  logic [COUNT_W-1:0] entry_count;

  record_scoreboard   sb;
  logic [KEY_W-1:0]   key_pool[POOL_SIZE];
  bit                 idle_on = 1'b1;
  int                 hold_requests = 0;
  int                 cycle_count = 0;

  keyed_record_table_core #(.DEPTH(DEPTH)) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .key         (key),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .payload_out (payload_out),
    .entry_count (entry_count)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Monitor: records every accepted request and checks every accepted response.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(mode, key, payload);
      if (out_valid && !out_stall) sb.check_response(ok, payload_out, entry_count);
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    int hold_served;
    int hold_left;
    if (rst) begin
      out_stall <= 1'b0;
      hold_served = 0;
      hold_left   = 0;
    end else begin
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (idle_on) begin
        out_stall <= ($urandom_range(99) < 17);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one request, with random gaps before it, and waits until it is taken.
  task automatic send_request(input logic [1:0] m, input logic [KEY_W-1:0] k,
                              input logic [PAY_W-1:0] p);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    key      <= k;
    payload  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering requests until every expected response has arrived.
  task automatic wait_for_responses();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Picks a key, favoring keys currently stored by the given percentage.
  function automatic logic [KEY_W-1:0] pick_key(int stored_pct);
    if (sb.fill > 0 && $urandom_range(99) < stored_pct)
      return sb.key_mem[$urandom_range(sb.fill - 1)];
    if ($urandom_range(99) < 8)
      return $urandom;
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  // Random traffic with the given mode mix, in percent.
  task automatic random_phase(int count, int w_ins, int w_del, int w_sel, int stored_pct);
    int               r;
    logic [1:0]       m;
    logic [PAY_W-1:0] p;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < w_ins) m = MODE_INSERT;
      else if (r < w_ins + w_del) m = MODE_DELETE;
      else if (r < w_ins + w_del + w_sel) m = MODE_SELECT;
      else m = MODE_UPDATE;
      r = $urandom_range(19);
      if (r == 0) p = '0;
      else if (r == 1) p = '1;
      else p = {$urandom, $urandom};
      send_request(m, pick_key(stored_pct), p);
    end
  endtask

  // Main sequence: reset, directed cases, random phases, then drain and report.
  initial begin
    sb = new();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h7fff_ffff;
    key_pool[3] = 32'hffff_ffff;
    key_pool[4] = 32'h0000_0001;
    key_pool[5] = 32'h5555_5555;
    key_pool[6] = 32'haaaa_aaaa;
    key_pool[7] = 32'hffff_fffe;
    for (int i = 8; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Misses on the empty table.
    send_request(MODE_SELECT, 32'd5, '1);
    send_request(MODE_DELETE, 32'd5, '1);
    send_request(MODE_UPDATE, 32'd5, '1);
    // Inserts with extreme keys and payloads, then a duplicate insert.
    send_request(MODE_INSERT, 32'h0000_0000, 64'h0);
    send_request(MODE_INSERT, 32'h8000_0000, 64'hffff_ffff_ffff_ffff);
    send_request(MODE_INSERT, 32'h7fff_ffff, 64'h5555_5555_5555_5555);
    send_request(MODE_INSERT, 32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa);
    send_request(MODE_INSERT, 32'h0000_0000, 64'h1234_5678_9abc_def0);
    // Selects of each stored key and one miss.
    send_request(MODE_SELECT, 32'h0000_0000, '1);
    send_request(MODE_SELECT, 32'h8000_0000, '0);
    send_request(MODE_SELECT, 32'h7fff_ffff, '0);
    send_request(MODE_SELECT, 32'hffff_ffff, '0);
    send_request(MODE_SELECT, 32'h0001_2345, '0);
    // Update hit and miss; select returns the new payload.
    send_request(MODE_UPDATE, 32'h7fff_ffff, 64'h0123_4567_89ab_cdef);
    send_request(MODE_SELECT, 32'h7fff_ffff, '0);
    send_request(MODE_UPDATE, 32'h0001_2345, '1);
    // Delete from the middle moves the last record; then empty the table.
    send_request(MODE_DELETE, 32'h8000_0000, '0);
    send_request(MODE_SELECT, 32'hffff_ffff, '0);
    send_request(MODE_DELETE, 32'hffff_ffff, '0);
    send_request(MODE_DELETE, 32'h0000_0000, '0);
    send_request(MODE_DELETE, 32'h7fff_ffff, '0);
    send_request(MODE_DELETE, 32'h7fff_ffff, '0);
    send_request(MODE_SELECT, 32'h8000_0000, '0);

    // Insert-heavy traffic fills the table and runs into the full case.
    random_phase(320, 60, 10, 15, 30);
    // Long receiver hold-off while requests keep coming.
    hold_requests++;
    random_phase(60, 25, 25, 25, 70);
    wait_for_responses();
    // A stretch with no idling on either side.
    idle_on = 1'b0;
    random_phase(300, 25, 25, 25, 60);
    idle_on = 1'b1;
    // Delete-heavy traffic drains the table.
    random_phase(320, 10, 55, 20, 80);
    random_phase(350, 30, 25, 25, 50);

    wait_for_responses();
    repeat (DEPTH + 10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
